// ----- rtl/core/rcp_pkg.sv -----
// Shared widths, command codes and status codes of the rectangle canvas painter.
package rcp_pkg;

   localparam int CMD_W   = 2;
   localparam int KIND_W  = 8;
   localparam int COORD_W = 20;
   localparam int BND_W   = COORD_W + 1;
   localparam int PIX_W   = 8;
   localparam int POS_W   = 9;
   localparam int SIDE_W  = 10;
   localparam int STAT_W  = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   localparam int DEF_MAX_SIDE  = 512;
   localparam int DEF_FRAC_BITS = 8;

   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_INVALID = 2'd1;
   localparam logic [STAT_W-1:0] STAT_OUTSIDE = 2'd2;

   localparam logic [KIND_W-1:0] KIND_OUTLINE = 8'h72;
   localparam logic [KIND_W-1:0] KIND_FILLED  = 8'h52;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BGCHAR = 2'd2;

   localparam logic [SIDE_W-1:0] WIDTH_RESET  = 10'd1;
   localparam logic [SIDE_W-1:0] HEIGHT_RESET = 10'd1;
   localparam logic [PIX_W-1:0]  BGCHAR_RESET = 8'd32;

endpackage

// ----- rtl/core/rcp_req_if.sv -----
// Command channel of the rectangle canvas painter.
interface rcp_req_if;
   import rcp_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [CMD_W-1:0]          cmd;
   logic [KIND_W-1:0]         shape_kind;
   logic signed [COORD_W-1:0] rect_x;
   logic signed [COORD_W-1:0] rect_y;
   logic signed [COORD_W-1:0] rect_width;
   logic signed [COORD_W-1:0] rect_height;
   logic [PIX_W-1:0]          ink;
   logic [POS_W-1:0]          pixel_col;
   logic [POS_W-1:0]          pixel_row;

   modport source (output valid, cmd, shape_kind, rect_x, rect_y, rect_width,
                   rect_height, ink, pixel_col, pixel_row, input ready);
   modport sink (input valid, cmd, shape_kind, rect_x, rect_y, rect_width,
                 rect_height, ink, pixel_col, pixel_row, output ready);
endinterface

// ----- rtl/core/rcp_rsp_if.sv -----
// Result channel of the rectangle canvas painter.
interface rcp_rsp_if;
   import rcp_pkg::*;

   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic [PIX_W-1:0]  pixel_value;
   logic              error_flag;

   modport source (output valid, status, pixel_value, error_flag, input ready);
   modport sink (input valid, status, pixel_value, error_flag, output ready);
endinterface

// ----- rtl/core/rcp_alu.sv -----
// Shared adder and arithmetic shifter that turns fixed-point edges into pixel bounds.
module rcp_alu #(
   parameter int FRAC_BITS = rcp_pkg::DEF_FRAC_BITS
) (
   input  logic signed [rcp_pkg::COORD_W-1:0] op_a,
   input  logic signed [rcp_pkg::COORD_W-1:0] op_b,
   output logic signed [rcp_pkg::BND_W-1:0]   result
);
   import rcp_pkg::*;

   logic signed [BND_W-1:0] sum;

   assign sum    = BND_W'(op_a) + BND_W'(op_b);
   assign result = sum >>> FRAC_BITS;
endmodule

// ----- rtl/core/rcp_canvas_mem.sv -----
// Canvas byte memory with one write port and one registered read port.
module rcp_canvas_mem #(
   parameter int DEPTH = rcp_pkg::DEF_MAX_SIDE * rcp_pkg::DEF_MAX_SIDE,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [rcp_pkg::PIX_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output logic [rcp_pkg::PIX_W-1:0] rd_data
);
   import rcp_pkg::*;

   logic [PIX_W-1:0] mem [DEPTH];
   logic [PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/core/rectangle_canvas_painter_core.sv -----
// Top level of the rectangle canvas painter: sequencer, sweep counters and result register.
// A clear or draw command walks every pixel of the effective canvas once, one pixel per
// cycle through the single write port of the canvas memory; a draw first passes through
// a setup state in which one shared adder turns the fixed-point edges into pixel bounds.
// A read goes through the registered memory read port; a rejected draw or an unused
// command goes straight to the result stage. The command channel is not ready while a
// command is in progress, but it takes a new command while the previous result still
// waits on the result channel. The canvas is not initialized after reset: issue a clear
// before reading any pixel.
module rectangle_canvas_painter_core #(
   parameter int MAX_SIDE  = rcp_pkg::DEF_MAX_SIDE,
   parameter int FRAC_BITS = rcp_pkg::DEF_FRAC_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [rcp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rcp_pkg::CSR_DATA_W-1:0] csr_wdata,
   rcp_req_if.sink                        req_chan,
   rcp_rsp_if.source                      rsp_chan
);
   import rcp_pkg::*;

   localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
   localparam int MEM_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic signed [COORD_W-1:0] ONE_MINUS = COORD_W'((1 << FRAC_BITS) - 1);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SETUP  = 5'b00010,
      ST_SWEEP  = 5'b00100,
      ST_READ   = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [SIDE_W-1:0] width_ff, height_ff;
   logic [PIX_W-1:0]  bgchar_ff;
   logic [SIDE_W-1:0] eff_w, eff_h;

   logic sticky_ff, sticky_in;

   // Latched command.
   logic                      clear_ff, clear_in;
   logic                      filled_ff, filled_in;
   logic                      use_rd_ff, use_rd_in;
   logic [STAT_W-1:0]         stat_ff, stat_in;
   logic [PIX_W-1:0]          ink_ff, ink_in;
   logic signed [COORD_W-1:0] rx_ff, ry_ff, rw_ff, rh_ff;
   logic [POS_W-1:0]          pc_ff, pr_ff;

   // Pixel bounds, inclusive, in whole units.
   logic signed [BND_W-1:0] xlo_ff, xhi_ff, ylo_ff, yhi_ff;
   logic [1:0]              step_ff, step_in;

   logic [SIDE_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [MEM_AW-1:0] addr_ff, addr_in, base_ff, base_in;

   logic                      rsp_valid_ff;
   logic [STAT_W-1:0]         rsp_status_ff;
   logic [PIX_W-1:0]          rsp_pix_ff;
   logic                      rsp_err_ff;

   logic signed [COORD_W-1:0] alu_a, alu_b;
   logic signed [BND_W-1:0]   alu_res;

   logic                      wr_en;
   logic                      rd_en;
   logic [MEM_AW-1:0]         rd_addr;
   logic [PIX_W-1:0]          rd_data;

   logic                      req_xfer, rsp_xfer, rsp_load;
   logic                      draw_bad;
   logic signed [BND_W-1:0]   col_s, row_s;
   logic                      in_x, in_y, edge_x, edge_y, covered;
   logic                      last_col, last_row;

   function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] r);
      logic [SIDE_W-1:0] v;
      if (r == '0) begin
         v = SIDE_W'(1);
      end else if (32'(r) > MAX_SIDE) begin
         v = SIDE_W'(MAX_SIDE);
      end else begin
         v = r;
      end
      return v;
   endfunction

   assign eff_w = eff_side(width_ff);
   assign eff_h = eff_side(height_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         bgchar_ff <= BGCHAR_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WIDTH:  width_ff  <= csr_wdata;
            CSR_HEIGHT: height_ff <= csr_wdata;
            CSR_BGCHAR: bgchar_ff <= csr_wdata[PIX_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_xfer = req_chan.valid && req_chan.ready;
   assign rsp_xfer = rsp_valid_ff && rsp_chan.ready;
   assign rsp_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_chan.ready);

   assign draw_bad = req_chan.rect_width[COORD_W-1] || (req_chan.rect_width == '0) ||
                     req_chan.rect_height[COORD_W-1] || (req_chan.rect_height == '0) ||
                     ((req_chan.shape_kind != KIND_OUTLINE) &&
                      (req_chan.shape_kind != KIND_FILLED));

   // Bound setup: left = ceil(x), right = floor(x+w), same for rows.
   always_comb begin
      case (step_ff)
         2'd0:    begin alu_a = rx_ff; alu_b = ONE_MINUS; end
         2'd1:    begin alu_a = rx_ff; alu_b = rw_ff;     end
         2'd2:    begin alu_a = ry_ff; alu_b = ONE_MINUS; end
         default: begin alu_a = ry_ff; alu_b = rh_ff;     end
      endcase
   end

   rcp_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
      .op_a   (alu_a),
      .op_b   (alu_b),
      .result (alu_res)
   );

   // A pixel lies within one unit of an edge exactly when it sits on a bound column or row.
   assign col_s    = $signed(BND_W'(col_ff));
   assign row_s    = $signed(BND_W'(row_ff));
   assign in_x     = (col_s >= xlo_ff) && (col_s <= xhi_ff);
   assign in_y     = (row_s >= ylo_ff) && (row_s <= yhi_ff);
   assign edge_x   = (col_s == xlo_ff) || (col_s == xhi_ff);
   assign edge_y   = (row_s == ylo_ff) || (row_s == yhi_ff);
   assign covered  = in_x && in_y && (filled_ff || edge_x || edge_y);
   assign last_col = (col_ff == eff_w - SIDE_W'(1));
   assign last_row = (row_ff == eff_h - SIDE_W'(1));

   assign wr_en   = (state_ff == ST_SWEEP) && (clear_ff || covered);
   assign rd_en   = (state_ff == ST_READ);
   assign rd_addr = MEM_AW'(32'(pr_ff) * MAX_SIDE + 32'(pc_ff));

   rcp_canvas_mem #(.DEPTH(DEPTH), .AW(MEM_AW)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (ink_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in  = state_ff;
      sticky_in = sticky_ff;
      clear_in  = clear_ff;
      filled_in = filled_ff;
      use_rd_in = use_rd_ff;
      stat_in   = stat_ff;
      ink_in    = ink_ff;
      step_in   = step_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      addr_in   = addr_ff;
      base_in   = base_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               stat_in   = STAT_OK;
               use_rd_in = 1'b0;
               clear_in  = 1'b0;
               filled_in = (req_chan.shape_kind == KIND_FILLED);
               ink_in    = req_chan.ink;
               step_in   = 2'd0;
               col_in    = '0;
               row_in    = '0;
               addr_in   = '0;
               base_in   = '0;
               case (req_chan.cmd)
                  CMD_CLEAR: begin
                     clear_in  = 1'b1;
                     ink_in    = bgchar_ff;
                     sticky_in = 1'b0;
                     state_in  = ST_SWEEP;
                  end
                  CMD_DRAW: begin
                     if (draw_bad) begin
                        stat_in   = STAT_INVALID;
                        sticky_in = 1'b1;
                        state_in  = ST_FINISH;
                     end else begin
                        state_in = ST_SETUP;
                     end
                  end
                  CMD_READ: begin
                     if ((SIDE_W'(req_chan.pixel_col) >= eff_w) ||
                         (SIDE_W'(req_chan.pixel_row) >= eff_h)) begin
                        stat_in  = STAT_OUTSIDE;
                        state_in = ST_FINISH;
                     end else begin
                        use_rd_in = 1'b1;
                        state_in  = ST_READ;
                     end
                  end
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_SETUP: begin
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (last_col) begin
               col_in = '0;
               if (last_row) begin
                  state_in = ST_FINISH;
               end else begin
                  row_in  = row_ff + SIDE_W'(1);
                  base_in = base_ff + MEM_AW'(MAX_SIDE);
                  addr_in = base_ff + MEM_AW'(MAX_SIDE);
               end
            end else begin
               col_in  = col_ff + SIDE_W'(1);
               addr_in = addr_ff + MEM_AW'(1);
            end
         end
         ST_READ: state_in = ST_FINISH;
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sticky_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         sticky_ff <= sticky_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_xfer) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      clear_ff  <= clear_in;
      filled_ff <= filled_in;
      use_rd_ff <= use_rd_in;
      stat_ff   <= stat_in;
      ink_ff    <= ink_in;
      step_ff   <= step_in;
      col_ff    <= col_in;
      row_ff    <= row_in;
      addr_ff   <= addr_in;
      base_ff   <= base_in;
      if (req_xfer) begin
         rx_ff <= req_chan.rect_x;
         ry_ff <= req_chan.rect_y;
         rw_ff <= req_chan.rect_width;
         rh_ff <= req_chan.rect_height;
         pc_ff <= req_chan.pixel_col;
         pr_ff <= req_chan.pixel_row;
      end
      if (state_ff == ST_SETUP) begin
         case (step_ff)
            2'd0:    xlo_ff <= alu_res;
            2'd1:    xhi_ff <= alu_res;
            2'd2:    ylo_ff <= alu_res;
            default: yhi_ff <= alu_res;
         endcase
      end
      if (rsp_load) begin
         rsp_status_ff <= stat_ff;
         rsp_pix_ff    <= use_rd_ff ? rd_data : '0;
         rsp_err_ff    <= sticky_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.pixel_value = rsp_pix_ff;
   assign rsp_chan.error_flag  = rsp_err_ff;
endmodule

// ----- bench/rectangle_canvas_painter_core_test.sv -----
// Self-checking testbench for the rectangle canvas painter: predicts every result and compares.
module rectangle_canvas_painter_core_test;
   import rcp_pkg::*;

   localparam int SIDE = DEF_MAX_SIDE;
   localparam int FRAC = DEF_FRAC_BITS;
   localparam longint ONE = longint'(1) << FRAC;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int LONG_HOLD_AFTER = 30;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int RANDOM_PHASES = 4;
   localparam int ITEMS_PER_PHASE = 18;

   typedef struct {
      logic [CMD_W-1:0]          cmd;
      logic [KIND_W-1:0]         kind;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] w;
      logic signed [COORD_W-1:0] h;
      logic [PIX_W-1:0]          ink;
      logic [POS_W-1:0]          col;
      logic [POS_W-1:0]          row;
      bit                        drain_first;
   } paint_cmd_type;

   typedef struct {
      logic [STAT_W-1:0] status;
      logic [PIX_W-1:0]  pixel;
      logic              err;
   } paint_result_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   rcp_req_if req_chan ();
   rcp_rsp_if rsp_chan ();

   rectangle_canvas_painter_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan)
   );

   // Predicted block state and configuration.
   bit [PIX_W-1:0]  canvas_model [SIDE*SIDE];
   bit              sticky_err;
   logic [SIDE_W-1:0] width_reg = WIDTH_RESET;
   logic [SIDE_W-1:0] height_reg = HEIGHT_RESET;
   logic [PIX_W-1:0]  bg_reg = BGCHAR_RESET;

   paint_cmd_type    pending_cmds [$];
   paint_result_type expected_results [$];

   paint_cmd_type offer_item;
   bit offering;
   bit send_burst;
   bit recv_burst;
   int gap_left;
   int stall_left;
   int fail_count;
   int results_checked;
   int n_clear, n_draw, n_rejected, n_read, n_outside, n_unused, settings_used;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic int eff_side(logic [SIDE_W-1:0] r);
      if (r == 0) return 1;
      if (r > SIDE) return SIDE;
      return int'(r);
   endfunction

   // Applies one accepted command to the predicted state and returns its result.
   function automatic paint_result_type paint_command(paint_cmd_type c);
      paint_result_type res;
      int cols, rows;
      longint rx, ry, rw, rh, px, py;
      bit filled, in_rect, near_edge;
      cols = eff_side(width_reg);
      rows = eff_side(height_reg);
      res.status = STAT_OK;
      res.pixel = '0;
      case (c.cmd)
         CMD_CLEAR: begin
            for (int r = 0; r < rows; r++)
               for (int k = 0; k < cols; k++)
                  canvas_model[r*SIDE + k] = bg_reg;
            sticky_err = 1'b0;
            n_clear++;
         end
         CMD_DRAW: begin
            n_draw++;
            rx = longint'(c.x);
            ry = longint'(c.y);
            rw = longint'(c.w);
            rh = longint'(c.h);
            filled = (c.kind == KIND_FILLED);
            if (rw <= 0 || rh <= 0 || (c.kind != KIND_OUTLINE && !filled)) begin
               res.status = STAT_INVALID;
               sticky_err = 1'b1;
               n_rejected++;
            end else begin
               for (int r = 0; r < rows; r++) begin
                  for (int k = 0; k < cols; k++) begin
                     px = longint'(k) << FRAC;
                     py = longint'(r) << FRAC;
                     in_rect = px >= rx && px <= rx + rw && py >= ry && py <= ry + rh;
                     near_edge = (px - rx < ONE) || (rx + rw - px < ONE) ||
                                 (py - ry < ONE) || (ry + rh - py < ONE);
                     if (in_rect && (filled || near_edge))
                        canvas_model[r*SIDE + k] = c.ink;
                  end
               end
            end
         end
         CMD_READ: begin
            n_read++;
            if (int'(c.col) >= cols || int'(c.row) >= rows) begin
               res.status = STAT_OUTSIDE;
               n_outside++;
            end else begin
               res.pixel = canvas_model[int'(c.row)*SIDE + int'(c.col)];
            end
         end
         default: n_unused++;
      endcase
      res.err = sticky_err;
      return res;
   endfunction

   // Fields that a command does not use still carry random values.
   function automatic paint_cmd_type filler(logic [CMD_W-1:0] cmd);
      paint_cmd_type c;
      c.cmd = cmd;
      c.kind = KIND_W'($urandom);
      c.x = COORD_W'($urandom);
      c.y = COORD_W'($urandom);
      c.w = COORD_W'($urandom);
      c.h = COORD_W'($urandom);
      c.ink = PIX_W'($urandom);
      c.col = POS_W'($urandom);
      c.row = POS_W'($urandom);
      c.drain_first = 1'b0;
      return c;
   endfunction

   function automatic paint_cmd_type draw_cmd(logic [KIND_W-1:0] kind, int x, int y,
                                              int w, int h, logic [PIX_W-1:0] ink);
      paint_cmd_type c;
      c = filler(CMD_DRAW);
      c.kind = kind;
      c.x = COORD_W'(x);
      c.y = COORD_W'(y);
      c.w = COORD_W'(w);
      c.h = COORD_W'(h);
      c.ink = ink;
      return c;
   endfunction

   function automatic paint_cmd_type read_cmd(int col, int row, bit drain);
      paint_cmd_type c;
      c = filler(CMD_READ);
      c.col = POS_W'(col);
      c.row = POS_W'(row);
      c.drain_first = drain;
      return c;
   endfunction

   // Edge a few units around the canvas, on whole units half of the time.
   function automatic logic signed [COORD_W-1:0] near_coord(int side);
      int v;
      v = $urandom_range(0, (side + 6) * 256) - 4 * 256;
      if ($urandom_range(0, 1) == 0) v = v & ~255;
      return COORD_W'(v);
   endfunction

   function automatic logic signed [COORD_W-1:0] near_size(int side);
      int v;
      v = $urandom_range(1, (side + 4) * 256);
      if ($urandom_range(0, 1) == 0) v = v & ~255;
      return COORD_W'(v);
   endfunction

   function automatic paint_cmd_type random_command(int cw, int ch);
      paint_cmd_type c;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         c = filler(CMD_CLEAR);
      end else if (pick < 12) begin
         c = filler(CMD_UNUSED);
      end else if (pick < 40) begin
         c = filler(CMD_READ);
         if ($urandom_range(0, 9) != 0) begin
            c.col = POS_W'($urandom_range(0, cw - 1));
            c.row = POS_W'($urandom_range(0, ch - 1));
         end
      end else begin
         c = filler(CMD_DRAW);
         if (pick < 92) begin
            c.kind = $urandom_range(0, 1) ? KIND_FILLED : KIND_OUTLINE;
            c.x = near_coord(cw);
            c.y = near_coord(ch);
            c.w = near_size(cw);
            c.h = near_size(ch);
         end else if (pick < 96) begin
            c.kind = $urandom_range(0, 1) ? KIND_FILLED : KIND_OUTLINE;
         end
      end
      c.drain_first = ($urandom_range(0, 11) == 0);
      return c;
   endfunction

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_WIDTH:  width_reg = val;
         CSR_HEIGHT: height_reg = val;
         CSR_BGCHAR: bg_reg = val[PIX_W-1:0];
         default: ;
      endcase
   endtask

   // Checked at the falling edge so that both clocked processes have settled.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_cmds.size() != 0 || offering || expected_results.size() != 0);
   endtask

   task automatic set_canvas(logic [SIDE_W-1:0] w, logic [SIDE_W-1:0] h, logic [PIX_W-1:0] bg);
      wait_idle();
      repeat (4) @(posedge clock);
      write_csr(CSR_WIDTH, w);
      write_csr(CSR_HEIGHT, h);
      write_csr(CSR_BGCHAR, CSR_DATA_W'(bg));
      @(posedge clock);
      settings_used++;
   endtask

   // Command driver.
   always @(posedge clock) begin
      paint_result_type predicted;
      if (reset) begin
         offering = 1'b0;
         gap_left = 0;
         req_chan.valid       <= 1'b0;
         req_chan.cmd         <= '0;
         req_chan.shape_kind  <= '0;
         req_chan.rect_x      <= '0;
         req_chan.rect_y      <= '0;
         req_chan.rect_width  <= '0;
         req_chan.rect_height <= '0;
         req_chan.ink         <= '0;
         req_chan.pixel_col   <= '0;
         req_chan.pixel_row   <= '0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            predicted = paint_command(offer_item);
            expected_results.push_back(predicted);
            offering = 1'b0;
            if ($urandom_range(0, 19) == 0) send_burst = !send_burst;
            gap_left = send_burst ? 0 : $urandom_range(0, 15);
         end
         if (!offering) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_cmds.size() != 0 &&
                         !(pending_cmds[0].drain_first && expected_results.size() != 0)) begin
               offer_item = pending_cmds.pop_front();
               offering = 1'b1;
            end
         end
         req_chan.valid       <= offering;
         req_chan.cmd         <= offer_item.cmd;
         req_chan.shape_kind  <= offer_item.kind;
         req_chan.rect_x      <= offer_item.x;
         req_chan.rect_y      <= offer_item.y;
         req_chan.rect_width  <= offer_item.w;
         req_chan.rect_height <= offer_item.h;
         req_chan.ink         <= offer_item.ink;
         req_chan.pixel_col   <= offer_item.col;
         req_chan.pixel_row   <= offer_item.row;
      end
   end

   // Result monitor and checker.
   always @(posedge clock) begin
      paint_result_type want;
      bit take;
      if (reset) begin
         stall_left = 0;
         rsp_chan.ready <= 1'b0;
      end else begin
         take = rsp_chan.ready;
         if (rsp_chan.valid && rsp_chan.ready) begin
            results_checked++;
            if (expected_results.size() == 0) begin
               $error("result transfer with no command outstanding");
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_chan.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_chan.status);
                  fail_count++;
               end
               if (rsp_chan.pixel_value !== want.pixel) begin
                  $error("pixel_value: expected %0h, got %0h", want.pixel, rsp_chan.pixel_value);
                  fail_count++;
               end
               if (rsp_chan.error_flag !== want.err) begin
                  $error("error_flag: expected %0d, got %0d", want.err, rsp_chan.error_flag);
                  fail_count++;
               end
            end
            take = 1'b0;
            // One long hold-off lets the command side back up behind the result.
            if (results_checked == LONG_HOLD_AFTER) begin
               stall_left = LONG_HOLD_CYCLES;
            end else begin
               if ($urandom_range(0, 19) == 0) recv_burst = !recv_burst;
               stall_left = recv_burst ? 0 : $urandom_range(0, 15);
            end
         end
         if (!take) begin
            if (stall_left > 0) stall_left--;
            else take = 1'b1;
         end
         rsp_chan.ready <= take;
      end
   end

   initial begin
      int cw, ch;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Reset-size canvas of one pixel: only reads outside it come before the first clear.
      pending_cmds.push_back(read_cmd(1, 0, 1'b0));
      pending_cmds.push_back(read_cmd(0, 511, 1'b0));
      pending_cmds.push_back(read_cmd(511, 511, 1'b0));
      pending_cmds.push_back(filler(CMD_CLEAR));
      pending_cmds.push_back(read_cmd(0, 0, 1'b0));
      pending_cmds.push_back(draw_cmd(8'h00, 0, 0, 256, 256, 8'h33));
      pending_cmds.push_back(draw_cmd(8'hFF, 0, 0, 256, 256, 8'h33));
      pending_cmds.push_back(read_cmd(0, 0, 1'b0));
      pending_cmds.push_back(draw_cmd(KIND_FILLED, 0, 0, 0, 256, 8'h44));
      pending_cmds.push_back(draw_cmd(KIND_OUTLINE, 0, 0, 256, -524288, 8'h44));
      pending_cmds.push_back(filler(CMD_CLEAR));
      pending_cmds.push_back(draw_cmd(KIND_FILLED, -524288, -524288, 524287, 524287, 8'h00));
      pending_cmds.push_back(draw_cmd(KIND_FILLED, 524287, 524287, 524287, 524287, 8'hFF));
      pending_cmds.push_back(draw_cmd(KIND_FILLED, 0, 0, 1, 1, 8'hA5));
      pending_cmds.push_back(read_cmd(0, 0, 1'b1));
      // The pixel lies deep inside this outline and must keep its value.
      pending_cmds.push_back(draw_cmd(KIND_OUTLINE, -512, -512, 1024, 1024, 8'h11));
      // Starts a fraction to the right of the pixel, so it misses it.
      pending_cmds.push_back(draw_cmd(KIND_FILLED, 1, 0, 524287, 524287, 8'h22));
      pending_cmds.push_back(read_cmd(0, 0, 1'b0));
      // The pixel sits exactly on the right edge of this outline.
      pending_cmds.push_back(draw_cmd(KIND_OUTLINE, -256, -256, 256, 512, 8'h5A));
      pending_cmds.push_back(read_cmd(0, 0, 1'b0));
      pending_cmds.push_back(filler(CMD_UNUSED));

      // Full-size canvas; this clear writes every pixel of the store once.
      set_canvas(10'd1023, 10'd512, 8'hFF);
      pending_cmds.push_back(filler(CMD_CLEAR));
      pending_cmds.push_back(read_cmd(511, 511, 1'b0));
      pending_cmds.push_back(draw_cmd(KIND_OUTLINE, 256, 128, 500 * 256, 400 * 256 + 64, 8'h0F));
      pending_cmds.push_back(read_cmd(1, 0, 1'b0));
      pending_cmds.push_back(read_cmd(255, 255, 1'b0));

      set_canvas(10'd0, 10'd1023, 8'h00);
      pending_cmds.push_back(filler(CMD_CLEAR));
      pending_cmds.push_back(read_cmd(1, 0, 1'b0));
      pending_cmds.push_back(draw_cmd(KIND_FILLED, 0, 500 * 256, 256, 256, 8'hC3));
      pending_cmds.push_back(read_cmd(0, 501, 1'b0));

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         cw = $urandom_range(1, 24);
         ch = $urandom_range(1, 24);
         set_canvas(SIDE_W'(cw), SIDE_W'(ch), PIX_W'($urandom_range(0, 255)));
         repeat (ITEMS_PER_PHASE) pending_cmds.push_back(random_command(cw, ch));
      end

      wait_idle();
      repeat (20) @(posedge clock);
      $display("Checked %0d results over %0d canvas settings:", results_checked, settings_used);
      $display("%0d clears, %0d draws (%0d rejected), %0d reads (%0d outside), %0d unused.",
               n_clear, n_draw, n_rejected, n_read, n_outside, n_unused);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("Timed out with %0d commands queued and %0d results outstanding.",
               pending_cmds.size(), expected_results.size());
      $display("FAILURE");
      $finish;
   end

endmodule
